// File: design/assert_macros.svh
// Assertion macros shared by the color balance RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CBAL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CBAL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/cbal_pkg.sv
// Types, codes and helpers shared by the color balance block.
package cbal_pkg;

	localparam int FRAME_PIXEL_BITS_DEF = 22;
	localparam int GAIN_FRAC_BITS_DEF   = 16;
	localparam int HIST_BINS            = 256;
	localparam int BIN_BITS             = 8;

	localparam logic [1:0] OP_PASS_A = 2'd0;
	localparam logic [1:0] OP_PASS_B = 2'd1;
	localparam logic [1:0] OP_APPLY  = 2'd2;

	localparam logic [1:0] MODE_WP  = 2'd0;
	localparam logic [1:0] MODE_GW  = 2'd1;
	localparam logic [1:0] MODE_PCT = 2'd2;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_PCT  = 1'b1;

	localparam logic [13:0] PCT_RESET = 14'd100;
	localparam logic [13:0] PCT_MIN   = 14'd1;
	localparam logic [13:0] PCT_MAX   = 14'd9999;
	localparam logic [13:0] PCT_FULL  = 14'd10000;

	localparam logic [7:0] TGT_WHITE = 8'd255;
	localparam logic [7:0] TGT_GRAY  = 8'd128;
	localparam logic [7:0] CH_MAX    = 8'd255;

	localparam logic [13:0] COEF_B   = 14'd1868;
	localparam logic [13:0] COEF_G   = 14'd9617;
	localparam logic [13:0] COEF_R   = 14'd4899;
	localparam logic [21:0] GRAY_RND = 22'd8192;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] blue_in;
		logic [7:0] green_in;
		logic [7:0] red_in;
		logic       frame_end;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] blue_out;
		logic [7:0] green_out;
		logic [7:0] red_out;
		logic       last_out;
	} pix_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WAIT, ST_HRD, ST_HADD, ST_HMUL, ST_HCMP,
		ST_GMUL, ST_GADD, ST_GDIV, ST_GSAV
	} state_t;

	typedef enum logic [1:0] {JOB_WP, JOB_GW, JOB_PCT, JOB_WALK} job_t;

	// histogram port commands
	typedef struct packed {
		logic                inc;
		logic                walk;
		logic                clr;
		logic [BIN_BITS-1:0] addr;
	} hist_cmd_t;

	function automatic logic [7:0] gray_of(logic [7:0] b, logic [7:0] g, logic [7:0] r);
		logic [21:0] acc;
		acc = 22'(b) * 22'(COEF_B) + 22'(g) * 22'(COEF_G) + 22'(r) * 22'(COEF_R) + GRAY_RND;
		return acc[21:14];
	endfunction

endpackage

// File: design/image_color_balance_core.sv
// Color balance core: statistics passes, gain derivation and pixel correction.
//
// Pixels enter one word per cycle on the pix channel and corrected pixels
// leave on the res channel through a four-word result queue, so apply words
// stream at one per cycle while the consumer keeps up. Statistics words also
// go at one per cycle; the percentile histogram is a 256-bin synchronous RAM
// updated read-modify-write over two stages with forwarding for repeated
// bins. The word that closes a statistics pass (frame_end on pass A, or on
// pass B in percentile mode) starts end-of-pass work and the input stalls
// until it is done: the percentile threshold walk reads the histogram one bin
// at a time through ST_HRD, ST_HADD, ST_HMUL and ST_HCMP, and each of the
// three gains goes through the ST_GMUL and ST_GADD setup states and a
// bit-serial divider of FRAME_PIXEL_BITS+GAIN_FRAC_BITS+10 steps. Gains carry
// GAIN_FRAC_BITS fractional bits; a zero reference gives gain zero.
// Registers: balance_mode at 0x0, percent_hundredths at 0x4.
`include "assert_macros.svh"

module image_color_balance_core import cbal_pkg::*; #(
	parameter int FRAME_PIXEL_BITS = FRAME_PIXEL_BITS_DEF,
	parameter int GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_ready,
	input  pix_in_t     pix,
	output logic        res_valid,
	input  logic        res_ready,
	output pix_out_t    res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW    = FRAME_PIXEL_BITS + 1;          // counts
	localparam int SW    = FRAME_PIXEL_BITS + 9;          // channel sums, cumulative
	localparam int GW    = GAIN_FRAC_BITS + 10;           // gains
	localparam int NUMW  = FRAME_PIXEL_BITS + GAIN_FRAC_BITS + 9;
	localparam int DVW   = NUMW + 1;
	localparam int PRODW = SW + 14;
	localparam int SCW   = GW + 8;
	localparam int FIFO_DEPTH = 4;

	localparam logic [CW-1:0]  CNT_MAX  = CW'(1) << FRAME_PIXEL_BITS;
	localparam logic [SW-1:0]  SUM_MAX  = SW'(CH_MAX) << FRAME_PIXEL_BITS;
	localparam logic [GW-1:0]  GAIN_MAX = '1;
	localparam logic [SCW-1:0] RND_HALF = SCW'(1) << (GAIN_FRAC_BITS - 1);

	// ---------------- configuration ----------------
	logic [1:0]  mode_q;
	logic [13:0] pct_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WP;
			pct_q  <= PCT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MODE: mode_q <= pwdata[1:0];
				REG_PCT:  pct_q  <= pwdata[13:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = 32'(mode_q);
			REG_PCT:  prdata = 32'(pct_q);
			default:  prdata = '0;
		endcase
	end

	// ---------------- state ----------------
	state_t          state_q, state_d;
	job_t            job_q, job_d;
	logic            s1_valid;
	pix_in_t         pix_s1;
	logic            blk_q, blk_set, pix_acc;
	logic [CW-1:0]   pixel_count_q, sel_q;
	logic [SW-1:0]   sum_q [3];
	logic [7:0]      bgray_q;
	logic [23:0]     bpix_q;
	logic [8:0]      thr_q;
	logic [GW-1:0]   gain_q [3];
	logic            pass_a_q, pass_b_q;

	// end-of-pass datapath
	logic [BIN_BITS-1:0] bin_q;
	logic [SW-1:0]       cum_q, ref_q;
	logic [PRODW-1:0]    prod_q, need_q;
	logic [1:0]          ch_q;
	logic [NUMW-1:0]     num_q;
	logic                zero_q;

	// apply pipeline and result queue
	logic            ap_s2, last_s2;
	logic [SCW-1:0]  prod_s2 [3];
	pix_out_t        fifo_q [FIFO_DEPTH];
	logic [1:0]      wr_q, rd_q;
	logic [2:0]      cnt_q;
	logic            res_pop;

	// ---------------- stage 1 decode ----------------
	logic [7:0]     gray_s1;
	logic [7:0]     pv [3];
	logic           pa, pb, ap, end_a, end_b, hit, take_bright;
	logic [CW-1:0]  base_cnt, base_sel, cnt_inc, sel_inc;
	logic [SW-1:0]  base_sum [3], sum_add [3], sum_new [3];
	logic [7:0]     base_bgray;

	assign pv[0]   = pix_s1.blue_in;
	assign pv[1]   = pix_s1.green_in;
	assign pv[2]   = pix_s1.red_in;
	assign gray_s1 = gray_of(pix_s1.blue_in, pix_s1.green_in, pix_s1.red_in);
	assign pa      = s1_valid && (pix_s1.opcode == OP_PASS_A);
	assign pb      = s1_valid && (pix_s1.opcode == OP_PASS_B) && (mode_q == MODE_PCT);
	assign ap      = s1_valid && (pix_s1.opcode == OP_APPLY);
	assign end_a   = pa && pix_s1.frame_end;
	assign end_b   = pb && pix_s1.frame_end;
	assign hit     = {1'b0, gray_s1} >= thr_q;

	// first word of a pass sees cleared statistics
	assign base_cnt   = pass_a_q ? pixel_count_q : '0;
	assign base_bgray = pass_a_q ? bgray_q : '0;
	assign base_sel   = (pb && pass_b_q) ? sel_q : '0;
	assign cnt_inc    = (base_cnt < CNT_MAX) ? base_cnt + CW'(1) : base_cnt;
	assign sel_inc    = (base_sel < CNT_MAX) ? base_sel + CW'(1) : base_sel;
	assign take_bright = (base_cnt == '0) || (gray_s1 > base_bgray);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			base_sum[c] = ((pa && pass_a_q) || (pb && pass_b_q)) ? sum_q[c] : '0;
			sum_add[c]  = base_sum[c] + SW'(pv[c]);
			sum_new[c]  = (sum_add[c] > SUM_MAX) ? SUM_MAX : sum_add[c];
		end
	end

	always_comb begin
		if (end_b)
			job_d = JOB_PCT;
		else if (mode_q == MODE_GW)
			job_d = JOB_GW;
		else if (mode_q == MODE_PCT)
			job_d = JOB_WALK;
		else
			job_d = JOB_WP;
	end

	// ---------------- input handshake ----------------
	assign pix_acc = pix_valid && pix_ready;
	assign blk_set = pix.frame_end && ((pix.opcode == OP_PASS_A) ||
		((pix.opcode == OP_PASS_B) && (mode_q == MODE_PCT)));
	assign pix_ready = (state_q == ST_IDLE) && !blk_q &&
		((cnt_q + 3'(ap) + 3'(ap_s2)) <= 3'(FIFO_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			blk_q    <= 1'b0;
		end else begin
			s1_valid <= pix_acc;
			blk_q    <= pix_acc && blk_set;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc)
			pix_s1 <= pix;
	end

	// ---------------- histogram ----------------
	hist_cmd_t     hcmd;
	logic [CW-1:0] hist_rd;
	logic          walk_rd;

	assign hcmd.inc  = pa && (mode_q == MODE_PCT);
	assign hcmd.walk = walk_rd;
	assign hcmd.clr  = pa && !pass_a_q;
	assign hcmd.addr = hcmd.inc ? gray_s1 : bin_q;

	cbal_hist #(.CW(CW)) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (hcmd),
		.rd_data (hist_rd)
	);

	// ---------------- divider ----------------
	logic           div_start, div_done;
	logic [DVW-1:0] div_q, div_num;

	assign div_num = DVW'(num_q) + DVW'(ref_q >> 1);

	cbal_div #(.DVW(DVW), .DSW(SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (ref_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// ---------------- end-of-pass sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (end_a || end_b) state_d = ST_WAIT;
			ST_WAIT: state_d = (job_q == JOB_WALK) ? ST_HRD : ST_GMUL;
			ST_HRD:  state_d = ST_HADD;
			ST_HADD: state_d = ST_HMUL;
			ST_HMUL: state_d = ST_HCMP;
			ST_HCMP: begin
				if ((prod_q >= need_q) || (bin_q == BIN_BITS'(HIST_BINS - 1)))
					state_d = ST_IDLE;
				else
					state_d = ST_HRD;
			end
			ST_GMUL: state_d = ST_GADD;
			ST_GADD: state_d = zero_q ? ST_GSAV : ST_GDIV;
			ST_GDIV: if (div_done) state_d = ST_GSAV;
			ST_GSAV: state_d = (ch_q == 2'd2) ? ST_IDLE : ST_GMUL;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		walk_rd   = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_HRD:  walk_rd   = 1'b1;
			ST_GADD: div_start = !zero_q;
			default: ;
		endcase
	end

	logic [13:0]    pct_c;
	logic [7:0]     tgt;
	logic [CW-1:0]  gcnt;
	logic [SW-1:0]  gref;

	always_comb begin
		if (pct_q < PCT_MIN)
			pct_c = PCT_FULL - PCT_MIN;
		else if (pct_q > PCT_MAX)
			pct_c = PCT_FULL - PCT_MAX;
		else
			pct_c = PCT_FULL - pct_q;
		case (job_q)
			JOB_GW: begin
				tgt  = TGT_GRAY;
				gcnt = pixel_count_q;
				gref = sum_q[ch_q];
			end
			JOB_PCT: begin
				tgt  = TGT_WHITE;
				gcnt = sel_q;
				gref = sum_q[ch_q];
			end
			default: begin
				tgt  = TGT_WHITE;
				gcnt = CW'(1);
				gref = SW'(bpix_q[ch_q*8 +: 8]);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= JOB_WP;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && (end_a || end_b))
				job_q <= job_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_WAIT: begin
				need_q <= PRODW'(pixel_count_q) * PRODW'(pct_c);
				bin_q  <= '0;
				cum_q  <= '0;
				ch_q   <= '0;
			end
			ST_HADD: cum_q  <= cum_q + SW'(hist_rd);
			ST_HMUL: prod_q <= PRODW'(cum_q) * PRODW'(PCT_FULL);
			ST_HCMP: bin_q  <= bin_q + BIN_BITS'(1);
			ST_GMUL: begin
				num_q  <= (NUMW'(tgt) * NUMW'(gcnt)) << GAIN_FRAC_BITS;
				ref_q  <= gref;
				zero_q <= (gref == '0) || (gcnt == '0);
			end
			ST_GSAV: ch_q <= ch_q + 2'd1;
			default: ;
		endcase
	end

	// ---------------- statistics registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= '0;
			sel_q         <= '0;
			bgray_q       <= '0;
			bpix_q        <= '0;
			thr_q         <= '0;
			pass_a_q      <= 1'b0;
			pass_b_q      <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				sum_q[c]  <= '0;
				gain_q[c] <= '0;
			end
		end else begin
			if (pa) begin
				pass_a_q      <= !pix_s1.frame_end;
				pixel_count_q <= cnt_inc;
				if (!pass_a_q) begin
					pass_b_q <= 1'b0;
					sel_q    <= '0;
				end
				if (mode_q == MODE_GW) begin
					for (int c = 0; c < 3; c++) sum_q[c] <= sum_new[c];
				end else if (!pass_a_q) begin
					for (int c = 0; c < 3; c++) sum_q[c] <= '0;
				end
				if (mode_q != MODE_GW && mode_q != MODE_PCT && take_bright) begin
					bgray_q <= gray_s1;
					bpix_q  <= {pix_s1.red_in, pix_s1.green_in, pix_s1.blue_in};
				end else if (!pass_a_q) begin
					bgray_q <= '0;
					bpix_q  <= '0;
				end
			end
			if (pb) begin
				pass_b_q <= !pix_s1.frame_end;
				if (hit) begin
					sel_q <= sel_inc;
					for (int c = 0; c < 3; c++) sum_q[c] <= sum_new[c];
				end else if (!pass_b_q) begin
					sel_q <= '0;
					for (int c = 0; c < 3; c++) sum_q[c] <= '0;
				end
			end
			if (state_q == ST_HCMP) begin
				if (prod_q >= need_q)
					thr_q <= 9'(bin_q) + 9'd1;
				else if (bin_q == BIN_BITS'(HIST_BINS - 1))
					thr_q <= '0;
			end
			if (state_q == ST_GSAV) begin
				if (zero_q)
					gain_q[ch_q] <= '0;
				else if (|div_q[DVW-1:GW])
					gain_q[ch_q] <= GAIN_MAX;
				else
					gain_q[ch_q] <= div_q[GW-1:0];
			end
		end
	end

	// ---------------- apply: multiply, then round and saturate ----------------
	logic [SCW-1:0] rnd [3];
	logic [SCW-1:0] shv [3];
	logic [7:0]     chv [3];
	pix_out_t       res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ap_s2 <= 1'b0;
		else
			ap_s2 <= ap;
	end

	always_ff @(posedge clk) begin
		last_s2 <= pix_s1.frame_end;
		for (int c = 0; c < 3; c++)
			prod_s2[c] <= SCW'(pv[c]) * SCW'(gain_q[c]);
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rnd[c] = prod_s2[c] + RND_HALF;
			shv[c] = rnd[c] >> GAIN_FRAC_BITS;
			chv[c] = (|shv[c][SCW-1:8]) ? CH_MAX : shv[c][7:0];
		end
		res_d.blue_out  = chv[0];
		res_d.green_out = chv[1];
		res_d.red_out   = chv[2];
		res_d.last_out  = last_s2;
	end

	// ---------------- result queue ----------------
	assign res_valid = (cnt_q != 3'd0);
	assign res       = fifo_q[rd_q];
	assign res_pop   = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (ap_s2)
				wr_q <= wr_q + 2'd1;
			if (res_pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(ap_s2) - 3'(res_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (ap_s2)
			fifo_q[wr_q] <= res_d;
	end

	// ---------------- checks ----------------
	`CBAL_ASSERT_IMPL(a_busy_stalls, state_q != ST_IDLE, !pix_ready, "input taken during end-of-pass work")
	`CBAL_ASSERT_IMPL(a_queue_room, ap_s2 && !res_pop, cnt_q != 3'(FIFO_DEPTH), "result queue overflow")
	`CBAL_ASSERT(a_pass_end_stalls, (pix_valid && pix_ready && blk_set) |=> !pix_ready, "input taken right after pass end")

endmodule

// File: design/cbal_hist.sv
// Gray histogram memory with read-modify-write increment and walk read.
module cbal_hist import cbal_pkg::*; #(
	parameter int CW = FRAME_PIXEL_BITS_DEF + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hist_cmd_t     cmd,
	output logic [CW-1:0] rd_data
);

	localparam logic [CW-1:0] CNT_MAX = CW'(1) << (CW - 1);

	logic [CW-1:0]       mem [HIST_BINS];
	logic [HIST_BINS-1:0] vld_q;
	logic [CW-1:0]       rdata_q;
	logic                inc_s2, vld_s2, fwd_s2;
	logic [BIN_BITS-1:0] addr_s2;
	logic [CW-1:0]       fwd_val_s2;
	logic [CW-1:0]       cur, nxt;

	// bin never written this frame reads as zero; back-to-back hits forward
	assign cur     = fwd_s2 ? fwd_val_s2 : (vld_s2 ? rdata_q : '0);
	assign nxt     = (cur < CNT_MAX) ? cur + CW'(1) : cur;
	assign rd_data = cur;

	always_ff @(posedge clk) begin
		if (cmd.inc || cmd.walk)
			rdata_q <= mem[cmd.addr];
		if (inc_s2)
			mem[addr_s2] <= nxt;
	end

	always_ff @(posedge clk) begin
		addr_s2    <= cmd.addr;
		fwd_val_s2 <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s2 <= 1'b0;
			vld_s2 <= 1'b0;
			fwd_s2 <= 1'b0;
			vld_q  <= '0;
		end else begin
			inc_s2 <= cmd.inc;
			if (cmd.inc || cmd.walk) begin
				vld_s2 <= vld_q[cmd.addr] && !cmd.clr;
				fwd_s2 <= inc_s2 && (addr_s2 == cmd.addr) && !cmd.clr;
			end
			if (cmd.clr)
				vld_q <= '0;
			else if (inc_s2)
				vld_q[addr_s2] <= 1'b1;
		end
	end

endmodule

// File: design/cbal_div.sv
// Restoring divider, one quotient bit per cycle.
module cbal_div import cbal_pkg::*; #(
	parameter int DVW = 48,
	parameter int DSW = 31
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DVW-1:0] dividend,
	input  logic [DSW-1:0] divisor,
	output logic           done,
	output logic [DVW-1:0] quotient
);

	localparam int CNTW = $clog2(DVW + 1);

	logic [DVW-1:0]  q_q;
	logic [DSW-1:0]  rem_q, dsr_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q, done_q;
	logic [DSW:0]    trial, diff;
	logic            ge;

	assign trial    = {rem_q, q_q[DVW-1]};
	assign ge       = trial >= {1'b0, dsr_q};
	assign diff     = trial - {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DVW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[DVW-2:0], ge};
			rem_q <= ge ? diff[DSW-1:0] : trial[DSW-1:0];
		end
	end

endmodule
